FILE: sv/salb_pkg.sv
`timescale 1ns / 1ps

package salb_pkg;

  // Request codes carried by req_type.
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_RANGE = 2'd2;

  // Status codes returned with every query result.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_BUILT = 2'd1;
  localparam logic [1:0] STAT_INVALID   = 2'd2;

  // Width of a range span (up to 1024 ranks) and of the range walk pointer.
  localparam int SPAN_W = 11;
  localparam int QW     = 12;

  // Sequencer states: build phases, query phases and result hand-off.
  typedef enum logic [5:0] {
    ST_IDLE,
    ST_INIT_RD, ST_INIT_WR,
    ST_CLR,
    ST_CNT_RD, ST_CNT_BK, ST_CNT_WR,
    ST_PFX_RD, ST_PFX_WR,
    ST_DST_SA, ST_DST_RK, ST_DST_BK, ST_DST_WR,
    ST_CPY_RD, ST_CPY_WR,
    ST_RNK_SA, ST_RNK_A, ST_RNK_K, ST_RNK_WR,
    ST_RCP_RD, ST_RCP_WR,
    ST_FIN_RD, ST_FIN_WR,
    ST_KAS_RK, ST_KAS_CHK, ST_KAS_J, ST_KAS_TI, ST_KAS_TJ, ST_KAS_CMP,
    ST_SPT_CHK, ST_SPT_A, ST_SPT_B, ST_SPT_WR,
    ST_Q_RD,
    ST_RMQ_SEL, ST_RMQ_FIRST, ST_RMQ_M, ST_RMQ_STEP, ST_RMQ_ACC,
    ST_OUT
  } state_t;

endpackage

FILE: sv/salb_lvl_sel.sv
`timescale 1ns / 1ps

module salb_lvl_sel #(
  parameter int LEVELS = 11,
  localparam int LVW = $clog2(LEVELS + 1)
) (
  input  logic [salb_pkg::SPAN_W-1:0] span,
  output logic [LVW-1:0]              lvl
);

  // Pick the highest table level whose block size still fits in the span.
  always_comb begin
    lvl = '0;
    for (int l = 0; l < LEVELS; l++) begin
      if ((1 << l) <= int'(span)) begin
        lvl = LVW'(l);
      end
    end
  end

endmodule

FILE: sv/suffix_array_lcp_builder_top.sv
`timescale 1ns / 1ps
// Loads are accepted back to back while idle. A read query passes through ST_Q_RD and ST_OUT;
// a range query walks ST_RMQ_SEL, ST_RMQ_FIRST and ST_RMQ_M, then ST_RMQ_STEP and ST_RMQ_ACC per
// table block, then ST_OUT. Input stays stalled until the result is handed off, and during the
// build after the last byte: the doubling rounds, the Kasai pass and the sparse-table pass.
// rst_n is synchronous: it clears the sequencer, text length, built flag and output valid;
// the memories are not cleared.

module suffix_array_lcp_builder_top #(
  parameter int MAX_LEN  = 1024,
  parameter int LEVELS   = 11,
  parameter int ALPHABET = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_symbol,
  input  logic        in_last_symbol,
  input  logic [9:0]  in_rank_lo,
  input  logic [9:0]  in_rank_hi,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_suffix_start,
  output logic [9:0]  out_rank_of_position,
  output logic [10:0] out_lcp_value,
  output logic [1:0]  out_status
);

  localparam int AW   = $clog2(MAX_LEN);
  localparam int LW   = $clog2(MAX_LEN + 1);
  localparam int NBK  = ((MAX_LEN > ALPHABET) ? MAX_LEN : ALPHABET) + 1;
  localparam int RW   = $clog2(NBK);
  localparam int IW   = $clog2(NBK + 1);
  localparam int KW   = LW + 1;
  localparam int XW   = ((IW > KW) ? IW : KW) + 1;
  localparam int LVW  = $clog2(LEVELS + 1);
  localparam int CW   = (((LEVELS + 1) > IW) ? (LEVELS + 1) : IW) + 1;
  localparam int MTD  = LEVELS * MAX_LEN;
  localparam int MTAW = $clog2(MTD);
  localparam int QW   = salb_pkg::QW;

  // Address of an entry of the level-major sparse min-table.
  function automatic logic [MTAW-1:0] mt_addr(input logic [LVW-1:0] lvl,
                                              input logic [AW-1:0] idx);
    mt_addr = MTAW'(lvl) * MTAW'(MAX_LEN) + MTAW'(idx);
  endfunction

  // Control and datapath registers.
  salb_pkg::state_t state_r, state_nxt;
  logic [LW-1:0]  len_r, len_nxt;
  logic           built_r, built_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [KW-1:0]  pk_r, pk_nxt;
  logic           pass_r, pass_nxt;
  logic [IW-1:0]  i_r, i_nxt;
  logic [LW-1:0]  sum_r, sum_nxt;
  logic [RW-1:0]  key_r, key_nxt;
  logic           kv_r, kv_nxt;
  logic [AW-1:0]  p_r, p_nxt;
  logic [LW-1:0]  rcnt_r, rcnt_nxt;
  logic [RW-1:0]  rka_r, rka_nxt;
  logic [RW-1:0]  prev_rk_r, prev_rk_nxt;
  logic [RW-1:0]  prev_key_r, prev_key_nxt;
  logic [LW-1:0]  h_r, h_nxt;
  logic [AW-1:0]  j_r, j_nxt;
  logic [AW-1:0]  rki_r, rki_nxt;
  logic [7:0]     ta_r, ta_nxt;
  logic [LVW-1:0] lv_r, lv_nxt;
  logic [LW-1:0]  m_r, m_nxt;
  logic [9:0]     qlo_r, qlo_nxt;
  logic [9:0]     qhi_r, qhi_nxt;
  logic [10:0]    size_r, size_nxt;
  logic [QW-1:0]  qp_r, qp_nxt;
  logic [9:0]     res_start_r, res_start_nxt;
  logic [9:0]     res_rank_r, res_rank_nxt;
  logic [10:0]    res_lcp_r, res_lcp_nxt;
  logic [1:0]     res_stat_r, res_stat_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [9:0]     out_start_r, out_start_nxt;
  logic [9:0]     out_rank_r, out_rank_nxt;
  logic [10:0]    out_lcp_r, out_lcp_nxt;
  logic [1:0]     out_stat_r, out_stat_nxt;

  // Memory ports.
  logic           t_we;
  logic [AW-1:0]  t_wa, t_ra;
  logic [7:0]     t_wd, t_rd;
  logic           sa_we;
  logic [AW-1:0]  sa_wa, sa_ra, sa_wd, sa_rd;
  logic           rk_we;
  logic [AW-1:0]  rk_wa, rk_ra;
  logic [RW-1:0]  rk_wd, rk_rd;
  logic           sc_we;
  logic [AW-1:0]  sc_wa, sc_ra;
  logic [RW-1:0]  sc_wd, sc_rd;
  logic           bk_we;
  logic [RW-1:0]  bk_wa, bk_ra;
  logic [LW-1:0]  bk_wd, bk_rd;
  logic            mt_we;
  logic [MTAW-1:0] mt_wa, mt_ra;
  logic [LW-1:0]   mt_wd, mt_rd;

  logic [7:0]     text_mem [MAX_LEN];
  logic [AW-1:0]  sa_mem   [MAX_LEN];
  logic [RW-1:0]  rk_mem   [MAX_LEN];
  logic [RW-1:0]  sc_mem   [MAX_LEN];
  logic [LW-1:0]  bk_mem   [NBK];
  logic [LW-1:0]  mt_mem   [MTD];

  // Shared loop conditions and derived values.
  logic                      accept;
  logic [IW-1:0]             n_i, nb_i, i_inc;
  logic                      more, bmore;
  logic [XW-1:0]             ipk, ppk, pk_ext, ak, ih, jh, n_x;
  logic [KW-1:0]             k2;
  logic                      done_k;
  logic                      kas_cond;
  logic [CW-1:0]             spt_end, spt_half;
  logic                      spt_fit;
  logic [salb_pkg::SPAN_W-1:0] span;
  logic [LVW-1:0]            sel_lv;
  logic [QW-1:0]             hi1, qp_end;
  logic                      step_ok;
  logic                      out_free;
  logic [7:0]                sym_c;
  logic [LW-1:0]             len_eff;
  logic                      lo_ok, range_ok;
  logic [RW-1:0]             key_now;
  logic                      differ;
  logic [LW-1:0]             rnew;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != salb_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign n_i    = IW'(len_r);
  assign nb_i   = (n_i > IW'(ALPHABET)) ? (n_i + IW'(1)) : IW'(ALPHABET + 1);
  assign i_inc  = i_r + IW'(1);
  assign more   = (i_inc < n_i);
  assign bmore  = (i_inc < nb_i);

  assign n_x    = XW'(len_r);
  assign pk_ext = XW'(pk_r);
  assign ipk    = XW'(i_r) + pk_ext;
  assign ppk    = XW'(sa_rd) + pk_ext;
  assign ak     = XW'(p_r) + XW'(k_r);
  assign ih     = XW'(i_r) + XW'(h_r);
  assign jh     = XW'(j_r) + XW'(h_r);
  assign kas_cond = (ih < n_x) && (jh < n_x);

  assign k2     = {k_r[KW-2:0], 1'b0};
  assign done_k = (rcnt_r == len_r) || (k2 >= KW'(len_r));

  assign spt_half = (CW'(1) << (lv_r - LVW'(1)));
  assign spt_end  = CW'(i_r) + (CW'(1) << lv_r);
  assign spt_fit  = (spt_end <= CW'(len_r));

  assign span    = salb_pkg::SPAN_W'(qhi_r) - salb_pkg::SPAN_W'(qlo_r)
                   + salb_pkg::SPAN_W'(1);
  assign hi1     = QW'(qhi_r) + QW'(1);
  assign qp_end  = qp_r + QW'(size_r);
  assign step_ok = (qp_end <= hi1);

  assign sym_c   = (9'(in_symbol) >= 9'(ALPHABET)) ? 8'(ALPHABET - 1) : in_symbol;
  assign len_eff = built_r ? '0 : len_r;
  assign lo_ok   = (int'(in_rank_lo) < int'(len_r));
  assign range_ok = (in_rank_lo <= in_rank_hi) && (int'(in_rank_hi) < int'(len_r));

  // Doubling key of the suffix whose second-half rank was read last cycle.
  assign key_now = kv_r ? rk_rd : '0;
  assign differ  = (i_r != '0) && ((rka_r != prev_rk_r) || (key_now != prev_key_r));
  assign rnew    = rcnt_r + LW'(differ);

  // Block-size level for range queries.
  salb_lvl_sel #(
    .LEVELS(LEVELS)
  ) u_lvl_sel (
    .span(span),
    .lvl (sel_lv)
  );

  // Memories: one write and one registered read per cycle each.
  always_ff @(posedge clk) begin
    if (t_we) begin
      text_mem[t_wa] <= t_wd;
    end
    t_rd <= text_mem[t_ra];
  end

  always_ff @(posedge clk) begin
    if (sa_we) begin
      sa_mem[sa_wa] <= sa_wd;
    end
    sa_rd <= sa_mem[sa_ra];
  end

  always_ff @(posedge clk) begin
    if (rk_we) begin
      rk_mem[rk_wa] <= rk_wd;
    end
    rk_rd <= rk_mem[rk_ra];
  end

  always_ff @(posedge clk) begin
    if (sc_we) begin
      sc_mem[sc_wa] <= sc_wd;
    end
    sc_rd <= sc_mem[sc_ra];
  end

  always_ff @(posedge clk) begin
    if (bk_we) begin
      bk_mem[bk_wa] <= bk_wd;
    end
    bk_rd <= bk_mem[bk_ra];
  end

  always_ff @(posedge clk) begin
    if (mt_we) begin
      mt_mem[mt_wa] <= mt_wd;
    end
    mt_rd <= mt_mem[mt_ra];
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      salb_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_req_type == salb_pkg::REQ_LOAD) begin
            state_nxt = in_last_symbol ? salb_pkg::ST_INIT_RD : salb_pkg::ST_IDLE;
          end else if (!built_r) begin
            state_nxt = salb_pkg::ST_OUT;
          end else if (in_req_type == salb_pkg::REQ_READ) begin
            state_nxt = lo_ok ? salb_pkg::ST_Q_RD : salb_pkg::ST_OUT;
          end else if (in_req_type == salb_pkg::REQ_RANGE) begin
            state_nxt = range_ok ? salb_pkg::ST_RMQ_SEL : salb_pkg::ST_OUT;
          end else begin
            state_nxt = salb_pkg::ST_OUT;
          end
        end
      end
      salb_pkg::ST_INIT_RD: state_nxt = salb_pkg::ST_INIT_WR;
      salb_pkg::ST_INIT_WR: begin
        if (more) begin
          state_nxt = salb_pkg::ST_INIT_RD;
        end else begin
          state_nxt = (len_r > LW'(1)) ? salb_pkg::ST_CLR : salb_pkg::ST_FIN_RD;
        end
      end
      salb_pkg::ST_CLR: state_nxt = bmore ? salb_pkg::ST_CLR : salb_pkg::ST_CNT_RD;
      salb_pkg::ST_CNT_RD: state_nxt = salb_pkg::ST_CNT_BK;
      salb_pkg::ST_CNT_BK: state_nxt = salb_pkg::ST_CNT_WR;
      salb_pkg::ST_CNT_WR: state_nxt = more ? salb_pkg::ST_CNT_RD : salb_pkg::ST_PFX_RD;
      salb_pkg::ST_PFX_RD: state_nxt = salb_pkg::ST_PFX_WR;
      salb_pkg::ST_PFX_WR: state_nxt = bmore ? salb_pkg::ST_PFX_RD : salb_pkg::ST_DST_SA;
      salb_pkg::ST_DST_SA: state_nxt = salb_pkg::ST_DST_RK;
      salb_pkg::ST_DST_RK: state_nxt = salb_pkg::ST_DST_BK;
      salb_pkg::ST_DST_BK: state_nxt = salb_pkg::ST_DST_WR;
      salb_pkg::ST_DST_WR: state_nxt = more ? salb_pkg::ST_DST_SA : salb_pkg::ST_CPY_RD;
      salb_pkg::ST_CPY_RD: state_nxt = salb_pkg::ST_CPY_WR;
      salb_pkg::ST_CPY_WR: begin
        if (more) begin
          state_nxt = salb_pkg::ST_CPY_RD;
        end else begin
          state_nxt = pass_r ? salb_pkg::ST_RNK_SA : salb_pkg::ST_CLR;
        end
      end
      salb_pkg::ST_RNK_SA: state_nxt = salb_pkg::ST_RNK_A;
      salb_pkg::ST_RNK_A:  state_nxt = salb_pkg::ST_RNK_K;
      salb_pkg::ST_RNK_K:  state_nxt = salb_pkg::ST_RNK_WR;
      salb_pkg::ST_RNK_WR: state_nxt = more ? salb_pkg::ST_RNK_SA : salb_pkg::ST_RCP_RD;
      salb_pkg::ST_RCP_RD: state_nxt = salb_pkg::ST_RCP_WR;
      salb_pkg::ST_RCP_WR: begin
        if (more) begin
          state_nxt = salb_pkg::ST_RCP_RD;
        end else begin
          state_nxt = done_k ? salb_pkg::ST_FIN_RD : salb_pkg::ST_CLR;
        end
      end
      salb_pkg::ST_FIN_RD: state_nxt = salb_pkg::ST_FIN_WR;
      salb_pkg::ST_FIN_WR: state_nxt = more ? salb_pkg::ST_FIN_RD : salb_pkg::ST_KAS_RK;
      salb_pkg::ST_KAS_RK: state_nxt = salb_pkg::ST_KAS_CHK;
      salb_pkg::ST_KAS_CHK: begin
        if (rk_rd != '0) begin
          state_nxt = salb_pkg::ST_KAS_J;
        end else begin
          state_nxt = more ? salb_pkg::ST_KAS_RK : salb_pkg::ST_SPT_CHK;
        end
      end
      salb_pkg::ST_KAS_J: state_nxt = salb_pkg::ST_KAS_TI;
      salb_pkg::ST_KAS_TI: begin
        if (kas_cond) begin
          state_nxt = salb_pkg::ST_KAS_TJ;
        end else begin
          state_nxt = more ? salb_pkg::ST_KAS_RK : salb_pkg::ST_SPT_CHK;
        end
      end
      salb_pkg::ST_KAS_TJ: state_nxt = salb_pkg::ST_KAS_CMP;
      salb_pkg::ST_KAS_CMP: begin
        if (t_rd == ta_r) begin
          state_nxt = salb_pkg::ST_KAS_TI;
        end else begin
          state_nxt = more ? salb_pkg::ST_KAS_RK : salb_pkg::ST_SPT_CHK;
        end
      end
      salb_pkg::ST_SPT_CHK: begin
        if (lv_r == LVW'(LEVELS)) begin
          state_nxt = salb_pkg::ST_IDLE;
        end else if (spt_fit) begin
          state_nxt = salb_pkg::ST_SPT_A;
        end
      end
      salb_pkg::ST_SPT_A:     state_nxt = salb_pkg::ST_SPT_B;
      salb_pkg::ST_SPT_B:     state_nxt = salb_pkg::ST_SPT_WR;
      salb_pkg::ST_SPT_WR:    state_nxt = salb_pkg::ST_SPT_CHK;
      salb_pkg::ST_Q_RD:      state_nxt = salb_pkg::ST_OUT;
      salb_pkg::ST_RMQ_SEL:   state_nxt = salb_pkg::ST_RMQ_FIRST;
      salb_pkg::ST_RMQ_FIRST: state_nxt = salb_pkg::ST_RMQ_M;
      salb_pkg::ST_RMQ_M:     state_nxt = salb_pkg::ST_RMQ_STEP;
      salb_pkg::ST_RMQ_STEP:  state_nxt = step_ok ? salb_pkg::ST_RMQ_ACC : salb_pkg::ST_OUT;
      salb_pkg::ST_RMQ_ACC:   state_nxt = salb_pkg::ST_RMQ_STEP;
      salb_pkg::ST_OUT:       state_nxt = out_free ? salb_pkg::ST_IDLE : salb_pkg::ST_OUT;
      default:                state_nxt = salb_pkg::ST_IDLE;
    endcase
  end

  // Memory controls and register updates for each sequencer state.
  always_comb begin
    len_nxt = len_r;           built_nxt = built_r;       k_nxt = k_r;
    pk_nxt = pk_r;             pass_nxt = pass_r;         i_nxt = i_r;
    sum_nxt = sum_r;           key_nxt = key_r;           kv_nxt = kv_r;
    p_nxt = p_r;               rcnt_nxt = rcnt_r;         rka_nxt = rka_r;
    prev_rk_nxt = prev_rk_r;   prev_key_nxt = prev_key_r; h_nxt = h_r;
    j_nxt = j_r;               rki_nxt = rki_r;           ta_nxt = ta_r;
    lv_nxt = lv_r;             m_nxt = m_r;               qlo_nxt = qlo_r;
    qhi_nxt = qhi_r;           size_nxt = size_r;         qp_nxt = qp_r;
    res_start_nxt = res_start_r;  res_rank_nxt = res_rank_r;
    res_lcp_nxt = res_lcp_r;      res_stat_nxt = res_stat_r;
    out_start_nxt = out_start_r;  out_rank_nxt = out_rank_r;
    out_lcp_nxt = out_lcp_r;      out_stat_nxt = out_stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    t_we = 1'b0;  t_wa = '0;  t_wd = '0;  t_ra = '0;
    sa_we = 1'b0; sa_wa = '0; sa_wd = '0; sa_ra = '0;
    rk_we = 1'b0; rk_wa = '0; rk_wd = '0; rk_ra = '0;
    sc_we = 1'b0; sc_wa = '0; sc_wd = '0; sc_ra = '0;
    bk_we = 1'b0; bk_wa = '0; bk_wd = '0; bk_ra = '0;
    mt_we = 1'b0; mt_wa = '0; mt_wd = '0; mt_ra = '0;

    case (state_r)
      // Loads append a byte; queries are checked and their reads issued.
      salb_pkg::ST_IDLE: begin
        sa_ra = AW'(in_rank_lo);
        rk_ra = AW'(in_rank_lo);
        mt_ra = MTAW'(AW'(in_rank_lo));
        if (accept) begin
          if (in_req_type == salb_pkg::REQ_LOAD) begin
            built_nxt = 1'b0;
            len_nxt   = len_eff;
            if (len_eff < LW'(MAX_LEN)) begin
              t_we    = 1'b1;
              t_wa    = AW'(len_eff);
              t_wd    = sym_c;
              len_nxt = len_eff + LW'(1);
            end
            i_nxt = '0;
          end else begin
            qlo_nxt       = in_rank_lo;
            qhi_nxt       = in_rank_hi;
            res_start_nxt = '0;
            res_rank_nxt  = '0;
            res_lcp_nxt   = '0;
            if (!built_r) begin
              res_stat_nxt = salb_pkg::STAT_NOT_BUILT;
            end else if (in_req_type == salb_pkg::REQ_READ) begin
              res_stat_nxt = lo_ok ? salb_pkg::STAT_OK : salb_pkg::STAT_INVALID;
            end else if (in_req_type == salb_pkg::REQ_RANGE) begin
              res_stat_nxt = range_ok ? salb_pkg::STAT_OK : salb_pkg::STAT_INVALID;
            end else begin
              res_stat_nxt = salb_pkg::STAT_INVALID;
            end
          end
        end
      end

      // Initial ranks are byte values plus one; order is the identity.
      salb_pkg::ST_INIT_RD: t_ra = AW'(i_r);
      salb_pkg::ST_INIT_WR: begin
        rk_we  = 1'b1;
        rk_wa  = AW'(i_r);
        rk_wd  = RW'(t_rd) + RW'(1);
        sa_we  = 1'b1;
        sa_wa  = AW'(i_r);
        sa_wd  = AW'(i_r);
        i_nxt  = more ? i_inc : '0;
        k_nxt    = KW'(1);
        pk_nxt   = KW'(1);
        pass_nxt = 1'b0;
      end

      // Counting sort: clear the buckets.
      salb_pkg::ST_CLR: begin
        bk_we = 1'b1;
        bk_wa = RW'(i_r);
        bk_wd = '0;
        i_nxt = bmore ? i_inc : '0;
      end

      // Counting sort: histogram of keys.
      salb_pkg::ST_CNT_RD: begin
        rk_ra  = AW'(ipk);
        kv_nxt = (ipk < n_x);
      end
      salb_pkg::ST_CNT_BK: begin
        bk_ra   = key_now;
        key_nxt = key_now;
      end
      salb_pkg::ST_CNT_WR: begin
        bk_we = 1'b1;
        bk_wa = key_r;
        bk_wd = bk_rd + LW'(1);
        i_nxt = more ? i_inc : '0;
        sum_nxt = '0;
      end

      // Counting sort: exclusive prefix sum over the buckets.
      salb_pkg::ST_PFX_RD: bk_ra = RW'(i_r);
      salb_pkg::ST_PFX_WR: begin
        bk_we   = 1'b1;
        bk_wa   = RW'(i_r);
        bk_wd   = sum_r;
        sum_nxt = sum_r + bk_rd;
        i_nxt   = bmore ? i_inc : '0;
      end

      // Counting sort: stable scatter into the scratch order.
      salb_pkg::ST_DST_SA: sa_ra = AW'(i_r);
      salb_pkg::ST_DST_RK: begin
        p_nxt  = sa_rd;
        rk_ra  = AW'(ppk);
        kv_nxt = (ppk < n_x);
      end
      salb_pkg::ST_DST_BK: begin
        bk_ra   = key_now;
        key_nxt = key_now;
      end
      salb_pkg::ST_DST_WR: begin
        sc_we = 1'b1;
        sc_wa = AW'(bk_rd);
        sc_wd = RW'(p_r);
        bk_we = 1'b1;
        bk_wa = key_r;
        bk_wd = bk_rd + LW'(1);
        i_nxt = more ? i_inc : '0;
      end

      // Copy the scattered order back; the second pass sorts on the first half.
      salb_pkg::ST_CPY_RD: sc_ra = AW'(i_r);
      salb_pkg::ST_CPY_WR: begin
        sa_we = 1'b1;
        sa_wa = AW'(i_r);
        sa_wd = AW'(sc_rd);
        i_nxt = more ? i_inc : '0;
        if (!more) begin
          if (pass_r) begin
            rcnt_nxt = LW'(1);
          end else begin
            pass_nxt = 1'b1;
            pk_nxt   = '0;
          end
        end
      end

      // New ranks: bump the counter whenever the rank pair changes.
      salb_pkg::ST_RNK_SA: sa_ra = AW'(i_r);
      salb_pkg::ST_RNK_A: begin
        p_nxt = sa_rd;
        rk_ra = sa_rd;
      end
      salb_pkg::ST_RNK_K: begin
        rka_nxt = rk_rd;
        rk_ra   = AW'(ak);
        kv_nxt  = (ak < n_x);
      end
      salb_pkg::ST_RNK_WR: begin
        sc_we        = 1'b1;
        sc_wa        = p_r;
        sc_wd        = RW'(rnew);
        rcnt_nxt     = rnew;
        prev_rk_nxt  = rka_r;
        prev_key_nxt = key_now;
        i_nxt        = more ? i_inc : '0;
      end

      // Copy the new ranks and decide whether another doubling round is due.
      salb_pkg::ST_RCP_RD: sc_ra = AW'(i_r);
      salb_pkg::ST_RCP_WR: begin
        rk_we = 1'b1;
        rk_wa = AW'(i_r);
        rk_wd = sc_rd;
        i_nxt = more ? i_inc : '0;
        if (!more && !done_k) begin
          k_nxt    = k2;
          pk_nxt   = k2;
          pass_nxt = 1'b0;
        end
      end

      // Final ranks are the inverse of the suffix order.
      salb_pkg::ST_FIN_RD: sa_ra = AW'(i_r);
      salb_pkg::ST_FIN_WR: begin
        rk_we = 1'b1;
        rk_wa = sa_rd;
        rk_wd = RW'(i_r);
        i_nxt = more ? i_inc : '0;
        h_nxt = '0;
        mt_we = !more;
        mt_wa = '0;
        mt_wd = '0;
      end

      // Kasai: walk positions in text order, extending the carried match length.
      salb_pkg::ST_KAS_RK: rk_ra = AW'(i_r);
      salb_pkg::ST_KAS_CHK: begin
        rki_nxt = AW'(rk_rd);
        sa_ra   = AW'(rk_rd - RW'(1));
        if (rk_rd == '0) begin
          h_nxt  = '0;
          i_nxt  = more ? i_inc : '0;
          lv_nxt = LVW'(1);
        end
      end
      salb_pkg::ST_KAS_J: j_nxt = sa_rd;
      salb_pkg::ST_KAS_TI: begin
        t_ra = AW'(ih);
        if (!kas_cond) begin
          mt_we  = 1'b1;
          mt_wa  = MTAW'(rki_r);
          mt_wd  = h_r;
          h_nxt  = (h_r != '0) ? (h_r - LW'(1)) : '0;
          i_nxt  = more ? i_inc : '0;
          lv_nxt = LVW'(1);
        end
      end
      salb_pkg::ST_KAS_TJ: begin
        ta_nxt = t_rd;
        t_ra   = AW'(jh);
      end
      salb_pkg::ST_KAS_CMP: begin
        if (t_rd == ta_r) begin
          h_nxt = h_r + LW'(1);
        end else begin
          mt_we  = 1'b1;
          mt_wa  = MTAW'(rki_r);
          mt_wd  = h_r;
          h_nxt  = (h_r != '0) ? (h_r - LW'(1)) : '0;
          i_nxt  = more ? i_inc : '0;
          lv_nxt = LVW'(1);
        end
      end

      // Sparse table: each level takes the minimum of two blocks of the level below.
      salb_pkg::ST_SPT_CHK: begin
        if (lv_r == LVW'(LEVELS)) begin
          built_nxt = 1'b1;
        end else if (!spt_fit) begin
          lv_nxt = lv_r + LVW'(1);
          i_nxt  = '0;
        end
      end
      salb_pkg::ST_SPT_A: mt_ra = mt_addr(lv_r - LVW'(1), AW'(i_r));
      salb_pkg::ST_SPT_B: begin
        m_nxt = mt_rd;
        mt_ra = mt_addr(lv_r - LVW'(1), AW'(CW'(i_r) + spt_half));
      end
      salb_pkg::ST_SPT_WR: begin
        mt_we = 1'b1;
        mt_wa = mt_addr(lv_r, AW'(i_r));
        mt_wd = (m_r < mt_rd) ? m_r : mt_rd;
        i_nxt = i_inc;
      end

      // Read query: order, rank and LCP of the addressed entry.
      salb_pkg::ST_Q_RD: begin
        res_start_nxt = 10'(sa_rd);
        res_rank_nxt  = 10'(rk_rd);
        res_lcp_nxt   = 11'(mt_rd);
      end

      // Range query: tail block first, then blocks from the range start.
      salb_pkg::ST_RMQ_SEL: begin
        lv_nxt   = sel_lv;
        size_nxt = 11'(1) << sel_lv;
      end
      salb_pkg::ST_RMQ_FIRST: mt_ra = mt_addr(lv_r, AW'(hi1 - QW'(size_r)));
      salb_pkg::ST_RMQ_M: begin
        m_nxt  = mt_rd;
        qp_nxt = QW'(qlo_r);
      end
      salb_pkg::ST_RMQ_STEP: begin
        mt_ra = mt_addr(lv_r, AW'(qp_r));
        if (step_ok) begin
          qp_nxt = qp_end;
        end else begin
          res_lcp_nxt = 11'(m_r);
        end
      end
      salb_pkg::ST_RMQ_ACC: m_nxt = (mt_rd < m_r) ? mt_rd : m_r;

      // Hand the result to the output register once it is free.
      salb_pkg::ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_start_nxt = res_start_r;
          out_rank_nxt  = res_rank_r;
          out_lcp_nxt   = res_lcp_r;
          out_stat_nxt  = res_stat_r;
        end
      end
      default: begin
        built_nxt = built_r;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= salb_pkg::ST_IDLE;
      len_r       <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      built_r     <= built_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    k_r <= k_nxt;             pk_r <= pk_nxt;             pass_r <= pass_nxt;
    i_r <= i_nxt;             sum_r <= sum_nxt;           key_r <= key_nxt;
    kv_r <= kv_nxt;           p_r <= p_nxt;               rcnt_r <= rcnt_nxt;
    rka_r <= rka_nxt;         prev_rk_r <= prev_rk_nxt;   prev_key_r <= prev_key_nxt;
    h_r <= h_nxt;             j_r <= j_nxt;               rki_r <= rki_nxt;
    ta_r <= ta_nxt;           lv_r <= lv_nxt;             m_r <= m_nxt;
    qlo_r <= qlo_nxt;         qhi_r <= qhi_nxt;           size_r <= size_nxt;
    qp_r <= qp_nxt;
    res_start_r <= res_start_nxt;  res_rank_r <= res_rank_nxt;
    res_lcp_r <= res_lcp_nxt;      res_stat_r <= res_stat_nxt;
    out_start_r <= out_start_nxt;  out_rank_r <= out_rank_nxt;
    out_lcp_r <= out_lcp_nxt;      out_stat_r <= out_stat_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_suffix_start     = out_start_r;
  assign out_rank_of_position = out_rank_r;
  assign out_lcp_value        = out_lcp_r;
  assign out_status           = out_stat_r;

  // A final byte always launches the build in the next cycle.
  a_build_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == salb_pkg::REQ_LOAD) && in_last_symbol)
      |=> (state_r == salb_pkg::ST_INIT_RD))
    else $error("build did not start after the final byte");

  // The built flag is only raised by the end of the sparse-table pass.
  a_built_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(built_r) |-> ($past(state_r) == salb_pkg::ST_SPT_CHK))
    else $error("built flag raised outside the table pass");

  // Distinct ranks can never outnumber the suffixes.
  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == salb_pkg::ST_RCP_RD) |-> (rcnt_r <= len_r))
    else $error("rank counter exceeds text length");

  // A query result is only loaded when the output register can take it.
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == salb_pkg::ST_OUT && out_valid_r && out_stall)
      |=> (state_r == salb_pkg::ST_OUT))
    else $error("sequencer left result hand-off while output was held");

endmodule

FILE: test/salb_checker.sv
`timescale 1ns / 1ps

module salb_checker
  import salb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_symbol,
  input  logic        in_last_symbol,
  input  logic [9:0]  in_rank_lo,
  input  logic [9:0]  in_rank_hi,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [9:0]  out_suffix_start,
  input  logic [9:0]  out_rank_of_position,
  input  logic [10:0] out_lcp_value,
  input  logic [1:0]  out_status,
  output int          fail_count,
  output int          pending
);

  localparam int TXT_MAX = 1024;
  localparam int TBL_LV  = 11;
  localparam int SYMS    = 256;

  typedef struct packed {
    logic [9:0]  start;
    logic [9:0]  rank;
    logic [10:0] lcp;
    logic [1:0]  status;
  } answer_t;

  answer_t answer_q[$];

  // Shadow copy of the text and of the built tables.
  logic [7:0] txt[TXT_MAX];
  int sfx[TXT_MAX];
  int rnk[TXT_MAX];
  int tmp_ord[TXT_MAX];
  int bkt[TXT_MAX + SYMS + 1];
  int lcp_tbl[TBL_LV][TXT_MAX];
  int txt_len;
  int nsort;
  bit is_built;

  initial begin
    fail_count = 0;
    pending    = 0;
    txt_len    = 0;
    is_built   = 0;
  end

  function automatic int key_of(int p, int k);
    return (p + k < nsort) ? rnk[p + k] : 0;
  endfunction

  // One stable counting sort of the suffix order on the rank k places ahead.
  task automatic count_sort(int k, int nb);
    int i, sum, t, p;
    sum = 0;
    for (i = 0; i < nb; i++) bkt[i] = 0;
    for (i = 0; i < nsort; i++) bkt[key_of(i, k)]++;
    for (i = 0; i < nb; i++) begin
      t = bkt[i];
      bkt[i] = sum;
      sum += t;
    end
    for (i = 0; i < nsort; i++) begin
      p = sfx[i];
      tmp_ord[bkt[key_of(p, k)]] = p;
      bkt[key_of(p, k)]++;
    end
    for (i = 0; i < nsort; i++) sfx[i] = tmp_ord[i];
  endtask

  // Prefix doubling, then Kasai's LCP pass, then the sparse min-table.
  task automatic build_tables();
    int i, k, r, h, j, lv, half, a, b, nb;
    nsort = txt_len;
    nb = ((nsort > SYMS) ? nsort : SYMS) + 1;
    for (i = 0; i < nsort; i++) begin
      rnk[i] = txt[i] + 1;
      sfx[i] = i;
    end
    for (k = 1; k < nsort; k = k << 1) begin
      count_sort(k, nb);
      count_sort(0, nb);
      r = 1;
      tmp_ord[sfx[0]] = r;
      for (i = 1; i < nsort; i++) begin
        a = sfx[i];
        b = sfx[i - 1];
        if (rnk[a] != rnk[b] || key_of(a, k) != key_of(b, k)) r++;
        tmp_ord[a] = r;
      end
      for (i = 0; i < nsort; i++) rnk[i] = tmp_ord[i];
      if (r == nsort) break;
    end
    for (i = 0; i < nsort; i++) rnk[sfx[i]] = i;

    lcp_tbl[0][0] = 0;
    h = 0;
    for (i = 0; i < nsort; i++) begin
      if (rnk[i] == 0) begin
        h = 0;
      end else begin
        j = sfx[rnk[i] - 1];
        while (i + h < nsort && j + h < nsort && txt[i + h] == txt[j + h]) h++;
        lcp_tbl[0][rnk[i]] = h;
        if (h > 0) h--;
      end
    end
    for (lv = 1; lv < TBL_LV; lv++) begin
      half = 1 << (lv - 1);
      for (i = 0; i + 2 * half <= nsort; i++) begin
        a = lcp_tbl[lv - 1][i];
        b = lcp_tbl[lv - 1][i + half];
        lcp_tbl[lv][i] = (a < b) ? a : b;
      end
    end
    is_built = 1;
  endtask

  function automatic int span_min(int lo, int hi);
    int len, lv, size, m, p;
    len = hi - lo + 1;
    lv = 0;
    while (lv + 1 < TBL_LV && (2 << lv) <= len) lv++;
    size = 1 << lv;
    m = lcp_tbl[lv][hi + 1 - size];
    for (p = lo; p + size <= hi + 1; p += size)
      if (lcp_tbl[lv][p] < m) m = lcp_tbl[lv][p];
    return m;
  endfunction

  // Transfers are judged at the falling edge, where every signal is settled;
  // a transfer seen here completes at the following rising edge.
  always @(negedge clk) begin
    answer_t ans, got;
    if (rst_n && in_valid && !in_stall) begin
      if (in_req_type == REQ_LOAD) begin
        if (is_built) begin
          is_built = 0;
          txt_len  = 0;
        end
        if (txt_len < TXT_MAX) begin
          txt[txt_len] = in_symbol;
          txt_len++;
        end
        if (in_last_symbol && txt_len > 0) build_tables();
      end else begin
        ans = '0;
        if (!is_built) begin
          ans.status = STAT_NOT_BUILT;
        end else if (in_req_type == REQ_READ) begin
          if (in_rank_lo >= txt_len) begin
            ans.status = STAT_INVALID;
          end else begin
            ans.start = sfx[in_rank_lo];
            ans.rank  = rnk[in_rank_lo];
            ans.lcp   = lcp_tbl[0][in_rank_lo];
          end
        end else if (in_req_type == REQ_RANGE) begin
          if (in_rank_lo > in_rank_hi || in_rank_hi >= txt_len)
            ans.status = STAT_INVALID;
          else
            ans.lcp = span_min(in_rank_lo, in_rank_hi);
        end else begin
          ans.status = STAT_INVALID;
        end
        answer_q.push_back(ans);
      end
    end

    // Result side: compare with the oldest outstanding answer.
    if (rst_n && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        $error("result transfer with no query outstanding");
        fail_count++;
      end else begin
        got = answer_q.pop_front();
        if (out_suffix_start !== got.start) begin
          $error("suffix_start expected %0d got %0d", got.start, out_suffix_start);
          fail_count++;
        end
        if (out_rank_of_position !== got.rank) begin
          $error("rank_of_position expected %0d got %0d", got.rank, out_rank_of_position);
          fail_count++;
        end
        if (out_lcp_value !== got.lcp) begin
          $error("lcp_value expected %0d got %0d", got.lcp, out_lcp_value);
          fail_count++;
        end
        if (out_status !== got.status) begin
          $error("status expected %0d got %0d", got.status, out_status);
          fail_count++;
        end
      end
    end
    pending = answer_q.size();
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import salb_pkg::*;

  localparam logic [1:0] REQ_BAD = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_req_type = REQ_LOAD;
  logic [7:0]  in_symbol = '0;
  logic        in_last_symbol = 1'b0;
  logic [9:0]  in_rank_lo = '0;
  logic [9:0]  in_rank_hi = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [9:0]  out_suffix_start;
  logic [9:0]  out_rank_of_position;
  logic [10:0] out_lcp_value;
  logic [1:0]  out_status;
  int          fail_count;
  int          pending;
  int          sent_items = 0;
  int          burst_left = 0;
  int          stall_cyc = 0;

  suffix_array_lcp_builder_top i_dut (.*);

  salb_checker i_checker (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // The receiver cycles through calm, sparse, periodic and heavy stalling.
  always @(posedge clk) begin
    stall_cyc <= stall_cyc + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      case (stall_cyc[9:8])
        2'd0: out_stall <= 1'b0;
        2'd1: out_stall <= ($urandom_range(0, 2) == 0);
        2'd2: out_stall <= (stall_cyc[3:0] < 6);
        default: out_stall <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  // One transfer on the input channel, with bursts and gaps around it.
  task automatic send(logic [1:0] rt, logic [7:0] sym, logic lst, int lo, int hi);
    int gap;
    logic stl;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_req_type    <= rt;
    in_symbol      <= sym;
    in_last_symbol <= lst;
    in_rank_lo     <= lo[9:0];
    in_rank_hi     <= hi[9:0];
    do begin
      @(negedge clk);
      stl = in_stall;
      @(posedge clk);
    end while (stl);
    burst_left--;
    sent_items++;
  endtask

  // A text of the given length over a small or full alphabet, then queries on it.
  task automatic text_round(int len, int alph);
    int i, base, qn, lo, hi, pick;
    base = $urandom_range(0, 256 - alph);
    for (i = 0; i < len; i++) begin
      send(REQ_LOAD, base + $urandom_range(0, alph - 1), i == len - 1,
           $urandom_range(0, 1023), $urandom_range(0, 1023));
      // Now and then a query lands in the middle of loading.
      if (i < len - 1 && $urandom_range(0, 60) == 0)
        send(REQ_READ, $urandom, $urandom, $urandom_range(0, 1023), $urandom_range(0, 1023));
    end
    if (len > 1024) len = 1024;
    qn = $urandom_range(5, 30);
    for (i = 0; i < qn; i++) begin
      pick = $urandom_range(0, 99);
      lo = $urandom_range(0, len - 1);
      hi = $urandom_range(lo, len - 1);
      if (pick < 60)
        send(REQ_READ, $urandom, $urandom, lo, $urandom_range(0, 1023));
      else if (pick < 65)
        send(REQ_READ, $urandom, $urandom, $urandom_range(0, 1023), $urandom_range(0, 1023));
      else if (pick < 90)
        send(REQ_RANGE, $urandom, $urandom, lo, hi);
      else if (pick < 97)
        send(REQ_RANGE, $urandom, $urandom, $urandom_range(0, 1023), $urandom_range(0, 1023));
      else
        send(REQ_BAD, $urandom, $urandom, $urandom_range(0, 1023), $urandom_range(0, 1023));
    end
  endtask

  initial begin
    int i, len, alph, sel;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: queries before any build, then a tiny text at the byte extremes.
    send(REQ_READ, 8'd0, 1'b0, 0, 0);
    send(REQ_RANGE, 8'd0, 1'b0, 0, 0);
    send(REQ_BAD, 8'd0, 1'b0, 1023, 1023);
    for (i = 0; i < 6; i++) send(REQ_LOAD, i[0] ? 8'd255 : 8'd0, i == 5, 0, 0);
    send(REQ_READ, 8'd0, 1'b0, 0, 0);
    send(REQ_READ, 8'd0, 1'b0, 5, 0);
    send(REQ_READ, 8'd0, 1'b0, 6, 0);
    send(REQ_READ, 8'd255, 1'b1, 1023, 1023);
    send(REQ_RANGE, 8'd0, 1'b0, 0, 5);
    send(REQ_RANGE, 8'd0, 1'b0, 3, 1);
    send(REQ_RANGE, 8'd0, 1'b0, 2, 1023);
    send(REQ_RANGE, 8'd0, 1'b0, 4, 4);
    send(REQ_BAD, 8'd255, 1'b1, 1023, 1023);

    // A text that overruns the store, so the tail bytes are dropped.
    text_round(1030, 256);

    // Random rounds, mostly short texts, some over one or two letters.
    while (sent_items < 1050) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 40);
      sel = $urandom_range(0, 4);
      alph = (sel == 0) ? 1 : (sel == 1) ? 2 : (sel == 2) ? 3 : (sel == 3) ? 4 : 256;
      text_round(len, alph);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
